// ===== design/paic_pkg.sv =====
// package for the panel analog input conditioner
// register indexes, field widths, route codes and the structs used by lanes and merge
// no dependencies
`default_nettype none

package paic_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int OFFSET_BITS     = 12;
    localparam int INVERT_BITS     = 7;
    localparam int AXIS_BITS       = 6;
    localparam int LEVEL_BITS      = 10;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 12;
    localparam int NUM_JOY         = 3;
    localparam int NUM_AUX         = 4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_CH0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_CH1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_CH2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INVERT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_MAP   = 3'd4;

    localparam logic [AXIS_BITS-1:0] AXIS_MAP_RESET = 6'd36;

    localparam logic [1:0] AXIS_CH0     = 2'd0;
    localparam logic [1:0] AXIS_CH1     = 2'd1;
    localparam logic [1:0] AXIS_CH2     = 2'd2;
    localparam logic [1:0] AXIS_CH2_ALT = 2'd3;

    // invert mask bit positions
    localparam int INV_FEED  = 3;
    localparam int INV_SPEED = 4;
    localparam int INV_MIST  = 5;
    localparam int INV_SPIT  = 6;

    // slots of the pass-through samples
    localparam int AUX_FEED  = 0;
    localparam int AUX_SPEED = 1;
    localparam int AUX_MIST  = 2;
    localparam int AUX_SPIT  = 3;

    typedef struct packed {
        logic signed [OFFSET_BITS-1:0] offset;
        logic                          invert;
    } paic_lane_cfg_t;

    typedef struct packed {
        logic [INVERT_BITS-1:0] invert;
        logic [AXIS_BITS-1:0]   axis_map;
    } paic_route_t;

endpackage

`default_nettype wire

// ===== design/paic_lane.sv =====
// one joystick lane: centre offset, half stretch through a pipelined divider, inversion
// depends on paic_pkg
`default_nettype none

module paic_lane #(
    parameter int SAMPLE_BITS = paic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic [SAMPLE_BITS-1:0]      raw,
    input  paic_pkg::paic_lane_cfg_t    cfg,
    output logic [SAMPLE_BITS-1:0]      value
);

    localparam int N     = SAMPLE_BITS;
    localparam int NW    = 2 * N - 1;
    localparam int MW    = N + 2;
    localparam int CW    = ((N > paic_pkg::OFFSET_BITS) ? N : paic_pkg::OFFSET_BITS) + 2;
    localparam int HALF  = (2 ** (N - 1)) - 1;
    localparam int LIMIT = HALF - 1;

    localparam logic signed [CW-1:0] LIM_POS = CW'(LIMIT);
    localparam logic signed [CW-1:0] LIM_NEG = CW'(-LIMIT);
    localparam logic signed [MW-1:0] HALF_S  = MW'(HALF);
    localparam logic signed [MW-1:0] HALF1_S = MW'(HALF + 1);
    localparam logic [N-1:0]         HALF_U  = N'(HALF);

    logic signed [CW-1:0] off_ext;
    logic signed [CW-1:0] off_cl;
    logic signed [MW-1:0] off_c;
    logic signed [MW-1:0] m_s;
    logic signed [MW-1:0] m_hi;
    logic signed [MW-1:0] dh_s;
    logic signed [MW-1:0] dl_s;
    logic                 hi_d;
    logic [NW-1:0]        num_d;
    logic [N-1:0]         div_d;

    logic [N-1:0] rem_reg [0:N];
    logic [N-1:0] rem_next [0:N];
    logic [N-1:0] low_reg [0:N];
    logic [N-1:0] low_next [0:N];
    logic [N-1:0] quo_reg [0:N];
    logic [N-1:0] quo_next [0:N];
    logic [N-1:0] div_reg [0:N];
    logic [N-1:0] div_next [0:N];
    logic         hi_reg [0:N];
    logic         hi_next [0:N];

    logic [N-1:0] fin;
    logic [N-1:0] value_reg;
    logic [N-1:0] value_next;

    // operand prep
    always_comb
    begin
        off_ext = {{(CW - paic_pkg::OFFSET_BITS){cfg.offset[paic_pkg::OFFSET_BITS-1]}},
                   cfg.offset};
        if (off_ext > LIM_POS)
        begin
            off_cl = LIM_POS;
        end
        else if (off_ext < LIM_NEG)
        begin
            off_cl = LIM_NEG;
        end
        else
        begin
            off_cl = off_ext;
        end
        off_c = off_cl[MW-1:0];
        m_s   = $signed({2'b00, raw}) + off_c;
        hi_d  = m_s > HALF_S;
        m_hi  = m_s - HALF_S;
        dh_s  = HALF1_S + off_c;
        dl_s  = HALF_S - off_c;
        if (hi_d)
        begin
            num_d = {m_hi[N-1:0], {(N-1){1'b0}}};
            div_d = dh_s[N-1:0];
        end
        else
        begin
            num_d = {raw, {(N-1){1'b0}}} - NW'(raw);
            div_d = dl_s[N-1:0];
        end
    end

    assign rem_next[0] = {1'b0, num_d[NW-1:N]};
    assign low_next[0] = num_d[N-1:0];
    assign quo_next[0] = '0;
    assign div_next[0] = div_d;
    assign hi_next[0]  = hi_d;

    // one quotient bit per stage
    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N:0] trial;
        logic [N:0] diff;
        logic       take;

        assign trial = {rem_reg[k], low_reg[k][N-1]};
        assign diff  = trial - {1'b0, div_reg[k]};
        assign take  = trial >= {1'b0, div_reg[k]};

        assign rem_next[k+1] = take ? diff[N-1:0] : trial[N-1:0];
        assign low_next[k+1] = {low_reg[k][N-2:0], 1'b0};
        assign quo_next[k+1] = {quo_reg[k][N-2:0], take};
        assign div_next[k+1] = div_reg[k];
        assign hi_next[k+1]  = hi_reg[k];
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= N; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            quo_reg[k] <= quo_next[k];
            div_reg[k] <= div_next[k];
            hi_reg[k]  <= hi_next[k];
        end
    end

    assign fin        = quo_reg[N] + (hi_reg[N] ? HALF_U : '0);
    assign value_next = cfg.invert ? ~fin : fin;

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== design/paic_merge.sv =====
// merge stage: axis routing of the lane results, 10-bit scaling, pot inversion
// depends on paic_pkg
`default_nettype none

module paic_merge #(
    parameter int SAMPLE_BITS = paic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                 clk,
    input  logic [paic_pkg::NUM_JOY-1:0][SAMPLE_BITS-1:0]        lane_val,
    input  logic [paic_pkg::NUM_AUX-1:0][SAMPLE_BITS-1:0]        aux_raw,
    input  paic_pkg::paic_route_t                                route,
    output logic [paic_pkg::LEVEL_BITS-1:0]                      stick_x,
    output logic [paic_pkg::LEVEL_BITS-1:0]                      stick_y,
    output logic [paic_pkg::LEVEL_BITS-1:0]                      stick_z,
    output logic [paic_pkg::LEVEL_BITS-1:0]                      feed_level,
    output logic [paic_pkg::LEVEL_BITS-1:0]                      speed_level,
    output logic [SAMPLE_BITS-1:0]                               mist_level,
    output logic [SAMPLE_BITS-1:0]                               spit_level
);

    localparam int N  = SAMPLE_BITS;
    localparam int LB = paic_pkg::LEVEL_BITS;
    localparam int XW = N + LB;
    localparam int SW = ((N > LB) ? N : LB) + 1;
    localparam int QW = LB + 1;
    localparam logic [N-1:0] FULL_U = '1;

    // v * 1023 / (2^N - 1) by folding the high part twice
    function automatic logic [LB-1:0] to_level(input logic [N-1:0] v);
        logic [XW-1:0]   x;
        logic [LB-1:0]   a;
        logic [N-1:0]    b;
        logic [SW-1:0]   s;
        logic [SW-N-1:0] a2;
        logic [N:0]      s2;
        logic [QW-1:0]   q;
        x  = {v, {LB{1'b0}}} - XW'(v);
        a  = x[XW-1:N];
        b  = x[N-1:0];
        s  = SW'(a) + SW'(b);
        a2 = s[SW-1:N];
        s2 = {1'b0, s[N-1:0]} + (N+1)'(a2);
        q  = QW'(a) + QW'(a2) + QW'(s2 >= {1'b0, FULL_U});
        return q[LB-1:0];
    endfunction

    logic [2:0][N-1:0] axis_val;
    logic [2:0][LB-1:0] stick_next;
    logic [2:0][LB-1:0] stick_reg;
    logic [N-1:0]  feed_v;
    logic [N-1:0]  speed_v;
    logic [LB-1:0] feed_reg;
    logic [LB-1:0] feed_next;
    logic [LB-1:0] speed_reg;
    logic [LB-1:0] speed_next;
    logic [N-1:0]  mist_reg;
    logic [N-1:0]  mist_next;
    logic [N-1:0]  spit_reg;
    logic [N-1:0]  spit_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (route.axis_map[2*i +: 2]) inside
                paic_pkg::AXIS_CH0:                        axis_val[i] = lane_val[0];
                paic_pkg::AXIS_CH1:                        axis_val[i] = lane_val[1];
                paic_pkg::AXIS_CH2, paic_pkg::AXIS_CH2_ALT: axis_val[i] = lane_val[2];
                default:                                   axis_val[i] = lane_val[2];
            endcase
            stick_next[i] = to_level(axis_val[i]);
        end
    end

    assign feed_v  = route.invert[paic_pkg::INV_FEED]  ? ~aux_raw[paic_pkg::AUX_FEED]
                                                       : aux_raw[paic_pkg::AUX_FEED];
    assign speed_v = route.invert[paic_pkg::INV_SPEED] ? ~aux_raw[paic_pkg::AUX_SPEED]
                                                       : aux_raw[paic_pkg::AUX_SPEED];
    assign feed_next  = to_level(feed_v);
    assign speed_next = to_level(speed_v);
    assign mist_next  = route.invert[paic_pkg::INV_MIST] ? ~aux_raw[paic_pkg::AUX_MIST]
                                                         : aux_raw[paic_pkg::AUX_MIST];
    assign spit_next  = route.invert[paic_pkg::INV_SPIT] ? ~aux_raw[paic_pkg::AUX_SPIT]
                                                         : aux_raw[paic_pkg::AUX_SPIT];

    always_ff @(posedge clk)
    begin
        stick_reg <= stick_next;
        feed_reg  <= feed_next;
        speed_reg <= speed_next;
        mist_reg  <= mist_next;
        spit_reg  <= spit_next;
    end

    assign stick_x     = stick_reg[0];
    assign stick_y     = stick_reg[1];
    assign stick_z     = stick_reg[2];
    assign feed_level  = feed_reg;
    assign speed_level = speed_reg;
    assign mist_level  = mist_reg;
    assign spit_level  = spit_reg;

endmodule

`default_nettype wire

// ===== design/panel_analog_input_conditioner.sv =====
// top level of the panel analog input conditioner: config registers, three lanes, merge
// depends on paic_pkg, paic_lane, paic_merge
`default_nettype none

// usage
// an item is one set of seven samples, taken on a clock edge with start high and busy low.
// busy stays low: a new item may be started every cycle.
// each item gives one result on the output ports, marked by done for a single cycle.
// an item passes through the per-lane divider, one quotient bit per stage, plus one prep,
// one lane finish and one merge stage; throughput is one item per cycle.
// the receiver cannot stall, so results are never held back.
// configuration uses cfg_valid/cfg_ready (ready always high) with cfg_index and cfg_data;
// write it only while no item is in flight.
// reset clears all in-flight items and sets offsets to zero, invert mask to zero and the
// axis map to x=ch0, y=ch1, z=ch2.
module panel_analog_input_conditioner #(
    parameter int SAMPLE_BITS = paic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [SAMPLE_BITS-1:0]                raw_ch0,
    input  logic [SAMPLE_BITS-1:0]                raw_ch1,
    input  logic [SAMPLE_BITS-1:0]                raw_ch2,
    input  logic [SAMPLE_BITS-1:0]                raw_feed,
    input  logic [SAMPLE_BITS-1:0]                raw_speed,
    input  logic [SAMPLE_BITS-1:0]                raw_mist,
    input  logic [SAMPLE_BITS-1:0]                raw_spit,
    output logic                                  done,
    output logic [paic_pkg::LEVEL_BITS-1:0]       stick_x,
    output logic [paic_pkg::LEVEL_BITS-1:0]       stick_y,
    output logic [paic_pkg::LEVEL_BITS-1:0]       stick_z,
    output logic [paic_pkg::LEVEL_BITS-1:0]       feed_level,
    output logic [paic_pkg::LEVEL_BITS-1:0]       speed_level,
    output logic [SAMPLE_BITS-1:0]                mist_level,
    output logic [SAMPLE_BITS-1:0]                spit_level,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [paic_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [paic_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int N   = SAMPLE_BITS;
    localparam int LAT = N + 3;
    localparam int AD  = N + 2;
    localparam int OB  = paic_pkg::OFFSET_BITS;

    logic accept;

    logic [OB-1:0]                        offset_reg [0:2];
    logic [OB-1:0]                        offset_next [0:2];
    logic [paic_pkg::INVERT_BITS-1:0]     invert_reg;
    logic [paic_pkg::INVERT_BITS-1:0]     invert_next;
    logic [paic_pkg::AXIS_BITS-1:0]       axis_reg;
    logic [paic_pkg::AXIS_BITS-1:0]       axis_next;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    logic [paic_pkg::NUM_AUX-1:0][N-1:0] aux_reg [0:AD-1];
    logic [paic_pkg::NUM_AUX-1:0][N-1:0] aux_in;

    logic [paic_pkg::NUM_JOY-1:0][N-1:0] raw_joy;
    logic [paic_pkg::NUM_JOY-1:0][N-1:0] lane_val;
    paic_pkg::paic_lane_cfg_t             lane_cfg [0:2];
    paic_pkg::paic_route_t                route;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // register writes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            offset_next[i] = offset_reg[i];
        end
        invert_next = invert_reg;
        axis_next   = axis_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                paic_pkg::CFG_OFFSET_CH0: offset_next[0] = cfg_data[OB-1:0];
                paic_pkg::CFG_OFFSET_CH1: offset_next[1] = cfg_data[OB-1:0];
                paic_pkg::CFG_OFFSET_CH2: offset_next[2] = cfg_data[OB-1:0];
                paic_pkg::CFG_INVERT:     invert_next = cfg_data[paic_pkg::INVERT_BITS-1:0];
                paic_pkg::CFG_AXIS_MAP:   axis_next   = cfg_data[paic_pkg::AXIS_BITS-1:0];
                default:                  invert_next = invert_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                offset_reg[i] <= '0;
            end
            invert_reg <= '0;
            axis_reg   <= paic_pkg::AXIS_MAP_RESET;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                offset_reg[i] <= offset_next[i];
            end
            invert_reg <= invert_next;
            axis_reg   <= axis_next;
        end
    end

    // item valid tracking
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[LAT-1];

    // pass-through samples delayed to meet the lanes
    always_comb
    begin
        aux_in                      = '0;
        aux_in[paic_pkg::AUX_FEED]  = raw_feed;
        aux_in[paic_pkg::AUX_SPEED] = raw_speed;
        aux_in[paic_pkg::AUX_MIST]  = raw_mist;
        aux_in[paic_pkg::AUX_SPIT]  = raw_spit;
    end

    always_ff @(posedge clk)
    begin
        aux_reg[0] <= aux_in;
        for (int k = 1; k < AD; k++)
        begin
            aux_reg[k] <= aux_reg[k-1];
        end
    end

    assign raw_joy[0] = raw_ch0;
    assign raw_joy[1] = raw_ch1;
    assign raw_joy[2] = raw_ch2;

    for (genvar i = 0; i < paic_pkg::NUM_JOY; i++)
    begin : g_lane
        assign lane_cfg[i].offset = offset_reg[i];
        assign lane_cfg[i].invert = invert_reg[i];

        paic_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .clk   (clk),
            .raw   (raw_joy[i]),
            .cfg   (lane_cfg[i]),
            .value (lane_val[i])
        );
    end

    assign route.invert   = invert_reg;
    assign route.axis_map = axis_reg;

    paic_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk         (clk),
        .lane_val    (lane_val),
        .aux_raw     (aux_reg[AD-1]),
        .route       (route),
        .stick_x     (stick_x),
        .stick_y     (stick_y),
        .stick_z     (stick_z),
        .feed_level  (feed_level),
        .speed_level (speed_level),
        .mist_level  (mist_level),
        .spit_level  (spit_level)
    );

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
    else $error("result strobe without a matching item");

    a_same_axis_same_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (axis_reg[1:0] == axis_reg[3:2])) |-> (stick_x == stick_y))
    else $error("x and y routed from one channel but differ");

    a_mist_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !invert_reg[paic_pkg::INV_MIST]) |-> (mist_level == $past(raw_mist, LAT)))
    else $error("mist level does not match its sample");
`endif

endmodule

`default_nettype wire
